// File: rtl/json_lexical_safety_checker_unit_assert.svh
// Assertion macros for the JSON lexical safety checker.
`ifndef JSON_LEXICAL_SAFETY_CHECKER_UNIT_ASSERT_SVH
`define JSON_LEXICAL_SAFETY_CHECKER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checks a property at every rising clock edge outside reset.
`define JLSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checks a property at every rising clock edge, reset included.
`define JLSC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define JLSC_ASSERT(label, prop, msg)
`define JLSC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/jlsc_pkg.sv
// Types and byte constants for the JSON lexical safety checker.
package jlsc_pkg;

	localparam int unsigned LimitWidth = 63;

	// One-hot scan modes.
	typedef enum logic [3:0] {
		MODE_OUT = 4'b0001,
		MODE_STR = 4'b0010,
		MODE_ESC = 4'b0100,
		MODE_NUM = 4'b1000
	} scan_mode_t;

	typedef enum logic [3:0] {
		RSN_NONE       = 4'd0,
		RSN_CTRL_STR   = 4'd1,
		RSN_NESTING    = 4'd2,
		RSN_STRAY      = 4'd3,
		RSN_FORBIDDEN  = 4'd4,
		RSN_LEAD_ZERO  = 4'd5,
		RSN_OVERFLOW   = 4'd6,
		RSN_BAD_TERM   = 4'd7,
		RSN_OPEN_STR   = 4'd8,
		RSN_OPEN_OBJ   = 4'd9
	} reason_t;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;

endpackage

// File: rtl/json_lexical_safety_checker_unit.sv
// The last byte is registered in the byte stage, then its verdict in the result register.
// Throughput: one byte per cycle unless a last byte waits on a blocked result register; the
// byte stage holds one multiply-by-ten add and a 67-bit compare against the number limit
// between its registers. Reset (arst_n low, asynchronous): scan state and valid flags clear, the
// number limit returns to its largest value; cfg writes set the limit.
`include "json_lexical_safety_checker_unit_assert.svh"
module json_lexical_safety_checker_unit
	import jlsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [LimitWidth-1:0] cfg_wr_data,  // number_limit
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,      // [7:0] data_byte
	input  logic                  s_tlast,      // last_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata       // [0] accepted, [4:1] failure_reason, [7:5] zero
);

	logic [LimitWidth-1:0] number_limit_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;

	scan_mode_t            mode_q, mode_d;
	logic                  obj_q, obj_d;
	logic [LimitWidth-1:0] value_q, value_d;
	logic                  lz_q, lz_d;
	reason_t               fail_q, fail_d;

	logic    out_valid_q;
	reason_t out_reason_q;

	logic                  is_digit, is_term, is_forbidden, go_outside;
	logic [3:0]            digit;
	logic [LimitWidth-1:0] base;
	logic [LimitWidth+3:0] sum;
	logic                  ovf;
	reason_t               rsn, verdict;

	// The byte stage moves on unless it holds a last byte and the result register is blocked.
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_limit_q <= '1;
		end else if (cfg_wr_en) begin
			number_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign is_digit     = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign digit        = 4'(byte_s1 - CH_ZERO);
	assign is_term      = (byte_s1 == CH_COMMA) || (byte_s1 == CH_RBRACE) ||
	                      (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB) ||
	                      (byte_s1 == CH_CR) || (byte_s1 == CH_LF) || (byte_s1 == CH_NUL);
	assign is_forbidden = (byte_s1 == CH_LBRACKET) || (byte_s1 == CH_RBRACKET) ||
	                      (byte_s1 == CH_MINUS) || (byte_s1 == CH_PLUS) || (byte_s1 == CH_DOT);

	// A digit outside a literal starts a new one from zero. Testing 10*v + d against
	// the limit gives the same answer as the division form of the overflow test.
	assign base = (mode_q == MODE_NUM) ? value_q : '0;
	assign sum  = ({4'b0, base} << 3) + ({4'b0, base} << 1) + {{LimitWidth{1'b0}}, digit};
	assign ovf  = sum > {4'b0, number_limit_q};

	always_comb begin
		mode_d     = mode_q;
		obj_d      = obj_q;
		value_d    = value_q;
		lz_d       = lz_q;
		rsn        = RSN_NONE;
		go_outside = 1'b0;
		case (mode_q)
			MODE_STR: begin
				if (byte_s1 == CH_BACKSLASH) begin
					mode_d = MODE_ESC;
				end else if (byte_s1 == CH_QUOTE) begin
					mode_d = MODE_OUT;
				end else if (byte_s1 < CH_SPACE) begin
					rsn = RSN_CTRL_STR;
				end
			end
			MODE_ESC: begin
				mode_d = MODE_STR;
			end
			MODE_NUM: begin
				if (is_digit) begin
					if (lz_q) begin
						rsn = RSN_LEAD_ZERO;
					end else if (ovf) begin
						rsn = RSN_OVERFLOW;
					end else begin
						value_d = sum[LimitWidth-1:0];
					end
				end else if (!is_term) begin
					rsn = RSN_BAD_TERM;
				end else begin
					mode_d     = MODE_OUT;
					go_outside = 1'b1;
				end
			end
			default: begin
				go_outside = 1'b1;
			end
		endcase
		if (go_outside) begin
			if (byte_s1 == CH_QUOTE) begin
				mode_d = MODE_STR;
			end else if (byte_s1 == CH_LBRACE) begin
				if (obj_q) begin
					rsn = RSN_NESTING;
				end else begin
					obj_d = 1'b1;
				end
			end else if (byte_s1 == CH_RBRACE) begin
				if (!obj_q) begin
					rsn = RSN_STRAY;
				end else begin
					obj_d = 1'b0;
				end
			end else if (is_forbidden) begin
				rsn = RSN_FORBIDDEN;
			end else if (is_digit) begin
				mode_d  = MODE_NUM;
				lz_d    = (byte_s1 == CH_ZERO);
				value_d = sum[LimitWidth-1:0];
				if (ovf) begin
					rsn = RSN_OVERFLOW;
				end
			end
		end
		// Once a failure is recorded, later bytes leave everything alone.
		if (fail_q != RSN_NONE) begin
			mode_d  = mode_q;
			obj_d   = obj_q;
			value_d = value_q;
			lz_d    = lz_q;
			fail_d  = fail_q;
		end else begin
			fail_d = rsn;
		end
		verdict = fail_d;
		if (verdict == RSN_NONE) begin
			if (mode_d == MODE_STR || mode_d == MODE_ESC) begin
				verdict = RSN_OPEN_STR;
			end else if (obj_d) begin
				verdict = RSN_OPEN_OBJ;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OUT;
			obj_q  <= 1'b0;
			lz_q   <= 1'b0;
			fail_q <= RSN_NONE;
		end else if (adv_s1) begin
			if (last_s1) begin
				mode_q <= MODE_OUT;
				obj_q  <= 1'b0;
				lz_q   <= 1'b0;
				fail_q <= RSN_NONE;
			end else begin
				mode_q <= mode_d;
				obj_q  <= obj_d;
				lz_q   <= lz_d;
				fail_q <= fail_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (adv_s1) begin
			value_q <= last_s1 ? '0 : value_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_reason_q <= verdict;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_reason_q, out_reason_q == RSN_NONE};

	`JLSC_ASSERT(a_mode_onehot, $onehot(mode_q), "scan mode is not one-hot")
	`JLSC_ASSERT(a_fail_sticks,
		(fail_q != RSN_NONE) && !(adv_s1 && last_s1) |=> fail_q == $past(fail_q),
		"recorded failure changed before the verdict")
	`JLSC_ASSERT(a_clear_after_verdict,
		adv_s1 && last_s1 |=> (mode_q == MODE_OUT) && !obj_q && (fail_q == RSN_NONE),
		"scan state not cleared after a verdict")
	`JLSC_ASSERT(a_result_held,
		out_valid_q && !m_tready |=> out_valid_q && $stable(out_reason_q),
		"pending verdict lost or changed while stalled")
	`JLSC_ASSERT(a_no_overrun,
		valid_s1 && last_s1 && out_valid_q && !m_tready |-> !s_tready,
		"input taken while its verdict cannot be stored")

endmodule
